// ===== design/bmc_pkg.sv =====
// Shared types, constants and bracket decode functions for the bracket match checker.
// Used by bmc_cell and bracket_match_checker_top; depends on nothing else.
`default_nettype none

package bmc_pkg;

  // Default number of stack entries.
  localparam int unsigned STACK_DEPTH_DEF = 64;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned CODE_W   = 2;
  localparam int unsigned REASON_W = 3;

  typedef logic [CODE_W-1:0] code_t;

  localparam code_t CODE_ROUND  = 2'd0;
  localparam code_t CODE_CURLY  = 2'd1;
  localparam code_t CODE_SQUARE = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_OPEN_ROUND   = 8'h28;
  localparam logic [CHAR_W-1:0] CHAR_CLOSE_ROUND  = 8'h29;
  localparam logic [CHAR_W-1:0] CHAR_OPEN_CURLY   = 8'h7b;
  localparam logic [CHAR_W-1:0] CHAR_CLOSE_CURLY  = 8'h7d;
  localparam logic [CHAR_W-1:0] CHAR_OPEN_SQUARE  = 8'h5b;
  localparam logic [CHAR_W-1:0] CHAR_CLOSE_SQUARE = 8'h5d;

  typedef enum logic [REASON_W-1:0] {
    REASON_OK       = 3'd0,
    REASON_MISMATCH = 3'd1,
    REASON_EMPTY    = 3'd2,
    REASON_UNCLOSED = 3'd3,
    REASON_OVERFLOW = 3'd4
  } reason_e;

  // Decoded bracket: hit is set when the byte is a bracket of the asked kind.
  typedef struct packed {
    logic  hit;
    code_t code;
  } bracket_t;

  // Shift command that every cell of the stack receives.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

  function automatic bracket_t opener_decode(input logic [CHAR_W-1:0] c);
    bracket_t r;
    r.hit  = 1'b1;
    r.code = CODE_ROUND;
    if (c == CHAR_OPEN_ROUND) begin
      r.code = CODE_ROUND;
    end else if (c == CHAR_OPEN_CURLY) begin
      r.code = CODE_CURLY;
    end else if (c == CHAR_OPEN_SQUARE) begin
      r.code = CODE_SQUARE;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  function automatic bracket_t closer_decode(input logic [CHAR_W-1:0] c);
    bracket_t r;
    r.hit  = 1'b1;
    r.code = CODE_ROUND;
    if (c == CHAR_CLOSE_ROUND) begin
      r.code = CODE_ROUND;
    end else if (c == CHAR_CLOSE_CURLY) begin
      r.code = CODE_CURLY;
    end else if (c == CHAR_CLOSE_SQUARE) begin
      r.code = CODE_SQUARE;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/bracket_match_checker_top.sv =====
// Top level of the bracket match checker: stream ports, fault tracking and the
// row of bmc_cell stack entries. Depends on bmc_pkg and bmc_cell.
//
// Usage: a string arrives on the slave stream one byte per transaction in
// s_axis_tdata, with s_axis_tlast set on its final byte. Round, curly and
// square openers are pushed on a stack of StackDepth entries built as a row
// of cells that shift toward the top on a pop and away from it on a push, so
// the top is always the first cell. A closer is compared against that cell.
// The first fault of a string is kept with its reason; later bytes of the
// string are ignored. Only the transaction carrying tlast produces a result
// on the master stream: tdata bit 0 is the verdict and bits 3:1 the reason.
// A byte is taken every cycle while s_axis_tready is high; the result appears
// in the cycle after the last byte is accepted, from an output register. While
// that register holds a result the receiver has not taken, s_axis_tready follows
// m_axis_tready, so a stalled receiver stalls the input with nothing lost.
// Reset empties the stack count, clears the fault and drops m_axis_tvalid; stack
// entries need no clearing since only entries below the count are ever read.
`default_nettype none

module bracket_match_checker_top #(
  parameter int unsigned StackDepth = bmc_pkg::STACK_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // [7:0] char_in
  input  wire logic       s_axis_tlast,  // last
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata   // [0] valid_res, [3:1] reason, [7:4] zero
);

  localparam int unsigned CntW = $clog2(StackDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(StackDepth);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              failed_q, failed_d;
  bmc_pkg::reason_e  reason_q, reason_d;
  logic              out_valid_q, out_valid_d;
  logic              out_ok_q, out_ok_d;
  bmc_pkg::reason_e  out_reason_q, out_reason_d;

  logic              accept;
  bmc_pkg::bracket_t opener;
  bmc_pkg::bracket_t closer;
  bmc_pkg::shift_t   shift;
  logic              fault_now;
  bmc_pkg::reason_e  fault_why;
  logic [CntW-1:0]   cnt_after;
  bmc_pkg::code_t    entry [StackDepth];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign opener        = bmc_pkg::opener_decode(s_axis_tdata);
  assign closer        = bmc_pkg::closer_decode(s_axis_tdata);

  always_comb begin
    shift     = '0;
    fault_now = 1'b0;
    fault_why = bmc_pkg::REASON_OK;
    cnt_after = cnt_q;
    if (accept && !failed_q) begin
      if (opener.hit) begin
        if (cnt_q == CntFull) begin
          fault_now = 1'b1;
          fault_why = bmc_pkg::REASON_OVERFLOW;
        end else begin
          shift.push = 1'b1;
          cnt_after  = cnt_q + CntW'(1);
        end
      end else if (closer.hit) begin
        if (cnt_q == '0) begin
          fault_now = 1'b1;
          fault_why = bmc_pkg::REASON_EMPTY;
        end else if (entry[0] == closer.code) begin
          shift.pop = 1'b1;
          cnt_after = cnt_q - CntW'(1);
        end else begin
          fault_now = 1'b1;
          fault_why = bmc_pkg::REASON_MISMATCH;
        end
      end else begin
        fault_now = 1'b1;
        fault_why = bmc_pkg::REASON_MISMATCH;
      end
    end
  end

  always_comb begin
    cnt_d        = cnt_after;
    failed_d     = failed_q || fault_now;
    reason_d     = failed_q ? reason_q : fault_why;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_ok_d     = out_ok_q;
    out_reason_d = out_reason_q;
    if (accept && s_axis_tlast) begin
      out_valid_d = 1'b1;
      if (failed_q || fault_now) begin
        out_ok_d     = 1'b0;
        out_reason_d = failed_q ? reason_q : fault_why;
      end else if (cnt_after != '0) begin
        out_ok_d     = 1'b0;
        out_reason_d = bmc_pkg::REASON_UNCLOSED;
      end else begin
        out_ok_d     = 1'b1;
        out_reason_d = bmc_pkg::REASON_OK;
      end
      cnt_d    = '0;
      failed_d = 1'b0;
      reason_d = bmc_pkg::REASON_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      failed_q    <= 1'b0;
      reason_q    <= bmc_pkg::REASON_OK;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      failed_q    <= failed_d;
      reason_q    <= reason_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ok_q     <= out_ok_d;
    out_reason_q <= out_reason_d;
  end

  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    bmc_pkg::code_t above;
    bmc_pkg::code_t below;
    if (i == 0) begin : g_first
      assign above = opener.code;
    end else begin : g_inner_above
      assign above = entry[i-1];
    end
    if (i == StackDepth - 1) begin : g_last
      assign below = entry[i];
    end else begin : g_inner_below
      assign below = entry[i+1];
    end
    bmc_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (shift),
      .above_i (above),
      .below_i (below),
      .entry_o (entry[i])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_reason_q, out_ok_q};

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("stack count exceeds the stack depth");

  a_last_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast |=> m_axis_tvalid && cnt_q == '0 && !failed_q)
    else $error("last byte did not produce a result and clear the string state");

  a_fault_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q && !(accept && s_axis_tlast) |=> failed_q && reason_q == $past(reason_q)
      && cnt_q == $past(cnt_q))
    else $error("latched fault changed before the end of the string");

  a_fail_has_reason : assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> reason_q != bmc_pkg::REASON_OK)
    else $error("fault latched without a reason");

endmodule

`default_nettype wire

// ===== design/bmc_cell.sv =====
// One entry of the shifting bracket stack: holds an opener code and takes its
// neighbor's entry on a push or a pop. Depends on bmc_pkg.
`default_nettype none

module bmc_cell (
  input  wire logic           clk_i,
  input  wire bmc_pkg::shift_t ctrl_i,
  input  wire bmc_pkg::code_t  above_i,
  input  wire bmc_pkg::code_t  below_i,
  output bmc_pkg::code_t       entry_o
);

  bmc_pkg::code_t entry_q;
  bmc_pkg::code_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      entry_d = above_i;
    end else if (ctrl_i.pop) begin
      entry_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire
